// File: rtl/weekly_window_ttl_calc_assert.svh
// Assertion macros for the weekly window lifetime calculator.
`ifndef WEEKLY_WINDOW_TTL_CALC_ASSERT_SVH
`define WEEKLY_WINDOW_TTL_CALC_ASSERT_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define WWT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define WWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wwt_pkg.sv
// Package with types and constants of the weekly window lifetime calculator.
package wwt_pkg;

   localparam int unsigned DAY_SECS   = 86400;
   localparam int unsigned WEEK_SECS  = 604800;
   localparam int unsigned PASS_LIMIT_DEF = 20;

   localparam logic [1:0] CSR_WEEK_MASK = 2'd0;
   localparam logic [1:0] CSR_WIN_EN    = 2'd1;
   localparam logic [1:0] CSR_WIN_START = 2'd2;
   localparam logic [1:0] CSR_WIN_END   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_LIMIT = 2'd2;

   typedef struct packed {
      logic [19:0]        week_time;
      logic signed [31:0] ttl_in;
      logic signed [31:0] elapsed;
   } req_type;

   typedef struct packed {
      logic signed [20:0] activity;
      logic signed [31:0] ttl_out;
      logic [1:0]         status;
   } rsp_type;

endpackage

// File: rtl/weekly_window_ttl_calc.sv
// Top level of the weekly window lifetime calculator.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_data (req_type)
//  rsp      out        rsp_valid/rsp_stall  rsp_data (rsp_type)
//  csr      in         csr_we               csr_index, csr_wdata
//
// An item runs from its transfer through window checks (a day split and a weekday scan)
// and passes, each pass followed by a new check; 20 passes plus the limit check make the
// longest case.
// Reset is synchronous; it clears the control state, the window enable and the window bounds, and sets the week mask.
// A result waits in its output register while rsp_stall is high, and the next item is
// taken meanwhile; that item's result waits until the register is free.
module weekly_window_ttl_calc
   import wwt_pkg::*;
#(
   parameter int unsigned PASS_LIMIT = PASS_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
`include "weekly_window_ttl_calc_assert.svh"

   localparam int PW = $clog2(PASS_LIMIT + 2);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WFOLD = 4'd1;
   localparam logic [3:0] S_DSPL  = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_SCAN  = 4'd4;
   localparam logic [3:0] S_ADDS  = 4'd5;
   localparam logic [3:0] S_PASS  = 4'd6;
   localparam logic [3:0] S_ADV   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [6:0]  mask_ff;
   logic        en_ff;
   logic [16:0] ws_ff, we_ff;

   logic [3:0]  st_ff, st_in;
   logic [20:0] wt_ff, wt_in;
   logic [2:0]  day_ff, day_in;
   logic [16:0] dt_ff, dt_in;
   logic signed [33:0] res_ff, res_in;
   logic [2:0]  k_ff, k_in;
   logic        first_ff, first_in;
   logic signed [33:0] ttl_ff, ttl_in;
   logic signed [33:0] up_ff, up_in;
   logic [PW-1:0] np_ff, np_in;
   logic signed [20:0] act0_ff, act0_in;
   logic        vout_ff, vout_in;
   rsp_type     rsp_ff, rsp_in;

   logic [16:0] s_f, e_f;
   logic [2:0]  dnext, dk;

   always_comb begin
      s_f = (ws_ff >= 17'(DAY_SECS)) ? ws_ff - 17'(DAY_SECS) : ws_ff;
      e_f = (we_ff >= 17'(DAY_SECS)) ? we_ff - 17'(DAY_SECS) : we_ff;
      dnext = (day_ff == 3'd6) ? 3'd0 : day_ff + 3'd1;
      dk = (3'(day_ff + k_ff) >= 3'd7 || day_ff + {1'b0, k_ff} >= 4'd7) ?
           3'(day_ff + {1'b0, k_ff} - 4'd7) : 3'(day_ff + k_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 7'h7f;
         en_ff <= 1'b0;
         ws_ff <= '0;
         we_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WEEK_MASK: mask_ff <= csr_wdata[6:0];
            CSR_WIN_EN:    en_ff <= csr_wdata[0];
            CSR_WIN_START: ws_ff <= csr_wdata;
            CSR_WIN_END:   we_ff <= csr_wdata;
            default:       mask_ff <= mask_ff;
         endcase
      end
   end

   always_comb begin
      logic signed [33:0] dts, ss, es, a, upm;
      st_in = st_ff; wt_in = wt_ff; day_in = day_ff; dt_in = dt_ff; res_in = res_ff;
      k_in = k_ff; first_in = first_ff; ttl_in = ttl_ff; up_in = up_ff; np_in = np_ff;
      act0_in = act0_ff; vout_in = vout_ff; rsp_in = rsp_ff;
      dts = 34'(dt_ff); ss = 34'(s_f); es = 34'(e_f);
      a = -res_ff;
      upm = (up_ff < a) ? up_ff : a;
      if (vout_ff && !rsp_stall) vout_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               wt_in = {1'b0, req_data.week_time};
               ttl_in = 34'(req_data.ttl_in);
               up_in = 34'(req_data.elapsed);
               np_in = '0;
               first_in = 1'b1;
               st_in = S_WFOLD;
            end
         end
         S_WFOLD: begin
            if (wt_ff >= 21'(WEEK_SECS)) wt_in = wt_ff - 21'(WEEK_SECS);
            day_in = '0;
            st_in = S_DSPL;
         end
         S_DSPL: begin
            if (wt_ff >= 21'(DAY_SECS) * (21'(day_ff) + 21'd1)) day_in = day_ff + 3'd1;
            else begin
               dt_in = 17'(wt_ff - 21'(DAY_SECS) * 21'(day_ff));
               st_in = (mask_ff == '0) ? S_OUT : S_CHK;
            end
         end
         S_CHK: begin
            k_in = 3'd1;
            if (!mask_ff[day_ff]) begin
               res_in = 34'(DAY_SECS) - dts; st_in = S_SCAN;
            end else if (!en_ff) begin
               res_in = '0; st_in = S_PASS;
            end else if (s_f < e_f) begin
               if (dt_ff < s_f) begin res_in = ss - dts; st_in = S_PASS; end
               else if (dt_ff >= e_f) begin res_in = 34'(DAY_SECS) - dts; st_in = S_SCAN; end
               else begin res_in = dts - es; st_in = S_PASS; end
            end else begin
               if (dt_ff >= e_f && dt_ff < s_f) begin res_in = ss - dts; st_in = S_PASS; end
               else begin
                  res_in = dts - 34'(DAY_SECS) - (mask_ff[dnext] ? es : 34'sd0);
                  st_in = S_PASS;
               end
            end
         end
         S_SCAN: begin
            if (mask_ff[dk] || k_ff == 3'd7) st_in = S_ADDS;
            else begin res_in = res_ff + 34'(DAY_SECS); k_in = k_ff + 3'd1; end
            if (mask_ff[dk] && k_ff == 3'd7) st_in = S_ADDS;
         end
         S_ADDS: begin
            if (!mask_ff[dk] && k_ff == 3'd7) res_in = res_ff + 34'(DAY_SECS);
            else if (en_ff && s_f < e_f) res_in = res_ff + ss;
            if (!mask_ff[dk] && k_ff == 3'd7 && en_ff && s_f < e_f) res_in = res_ff + 34'(DAY_SECS) + ss;
            st_in = S_PASS;
         end
         S_PASS: begin
            if (first_ff) act0_in = 21'(res_ff);
            first_in = 1'b0;
            if (ttl_ff <= 0 || up_ff <= 0) st_in = S_OUT;
            else if (32'(np_ff) + 1 > PASS_LIMIT) begin
               ttl_in = -34'sd1; np_in = np_ff + 1'b1; st_in = S_OUT;
            end else begin
               np_in = np_ff + 1'b1;
               if (res_ff > 0) begin up_in = up_ff - res_ff; wt_in = 21'(34'(wt_ff) + res_ff); end
               else begin up_in = up_ff - upm; ttl_in = ttl_ff - upm; wt_in = 21'(34'(wt_ff) + upm); end
               st_in = S_ADV;
            end
         end
         S_ADV: begin
            if (ttl_ff <= 0 || up_ff <= 0) st_in = S_OUT;
            else st_in = S_WFOLD;
         end
         S_OUT: begin
            if (!vout_ff || !rsp_stall) begin
               rsp_in.activity = (mask_ff == '0) ? '0 : act0_ff;
               rsp_in.ttl_out = ttl_ff[31:0];
               rsp_in.status = (mask_ff == '0) ? STAT_EMPTY :
                               (32'(np_ff) > PASS_LIMIT) ? STAT_LIMIT : STAT_OK;
               vout_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         vout_ff <= 1'b0;
         np_ff <= '0;
      end else begin
         st_ff <= st_in;
         vout_ff <= vout_in;
         np_ff <= np_in;
      end
      wt_ff <= wt_in; day_ff <= day_in; dt_ff <= dt_in; res_ff <= res_in; k_ff <= k_in;
      first_ff <= first_in; ttl_ff <= ttl_in; up_ff <= up_in;
      act0_ff <= act0_in; rsp_ff <= rsp_in;
   end

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = vout_ff;
   assign rsp_data  = rsp_ff;

   `WWT_ASSERT_IMPLY(a_busy_stall, clock, reset, st_ff != S_IDLE, req_stall, "busy but ready")
   `WWT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "stalled result changed")
   `WWT_ASSERT_IMPLY(a_np, clock, reset, 1'b1, 32'(np_ff) <= PASS_LIMIT + 1, "pass count overrun")

endmodule
